### sv/vsa_pkg.sv
// Package for the VRAM scroll address unit.
// Holds the transfer payload types, the scroll state type and the request codes.
// No dependencies.
`default_nettype none

package vsa_pkg;

    localparam int unsigned ADDR_W  = 15;
    localparam int unsigned FETCH_W = 14;

    localparam logic [3:0] REQ_CTRL_WR   = 4'd0;
    localparam logic [3:0] REQ_SCROLL_WR = 4'd1;
    localparam logic [3:0] REQ_ADDR_WR   = 4'd2;
    localparam logic [3:0] REQ_DATA      = 4'd3;
    localparam logic [3:0] REQ_STATUS_RD = 4'd4;
    localparam logic [3:0] REQ_INC_X     = 4'd5;
    localparam logic [3:0] REQ_INC_Y     = 4'd6;
    localparam logic [3:0] REQ_COPY_X    = 4'd7;
    localparam logic [3:0] REQ_COPY_Y    = 4'd8;

    localparam logic [4:0] COARSE_MAX     = 5'd31;
    localparam logic [4:0] COARSE_Y_LAST  = 5'd29;
    localparam logic [2:0] FINE_Y_MAX     = 3'd7;
    localparam logic [ADDR_W-1:0] ROW_STEP = 15'd32;
    localparam logic [ADDR_W-1:0] COL_STEP = 15'd1;
    localparam logic [ADDR_W-1:0] HORIZ_MASK = 15'h041F;
    localparam logic [ADDR_W-1:0] VERT_MASK  = 15'h7BE0;
    localparam logic [FETCH_W-1:0] NT_BASE   = 14'h2000;
    localparam logic [FETCH_W-1:0] ATTR_BASE = 14'h23C0;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] data_byte;
        logic       render_on;
    } t_in_item;

    typedef struct packed {
        logic [ADDR_W-1:0]  current_addr;
        logic [ADDR_W-1:0]  access_addr;
        logic [ADDR_W-1:0]  temp_addr;
        logic [2:0]         fine_x_out;
        logic               toggle_out;
        logic [FETCH_W-1:0] nametable_fetch;
        logic [FETCH_W-1:0] attribute_fetch;
    } t_out_item;

    typedef struct packed {
        logic [ADDR_W-1:0] cur_addr;
        logic [ADDR_W-1:0] tmp_addr;
        logic [2:0]        fine_scroll_x;
        logic              second_write;
        logic              step_by_row;
    } t_scroll_state;

endpackage

`default_nettype wire

### sv/vsa_step.sv
// Next-state and result logic for one request of the scroll address unit.
// Purely combinational; uses vsa_pkg.
`default_nettype none

module vsa_step (
    input  vsa_pkg::t_scroll_state i_state,
    input  vsa_pkg::t_in_item      i_item,
    output vsa_pkg::t_scroll_state o_state,
    output vsa_pkg::t_out_item     o_result
);

    logic [vsa_pkg::ADDR_W-1:0] v;
    logic [vsa_pkg::ADDR_W-1:0] v_inc_x;
    logic [vsa_pkg::ADDR_W-1:0] v_inc_y;
    logic [4:0]                 cy;
    logic [4:0]                 cy_next;
    logic                       nt_y_flip;

    assign v = i_state.cur_addr;

    always_comb begin
        if (v[4:0] == vsa_pkg::COARSE_MAX) begin
            v_inc_x = {v[14:11], ~v[10], v[9:5], 5'd0};
        end else begin
            v_inc_x = {v[14:5], v[4:0] + 5'd1};
        end
    end

    assign cy = v[9:5];

    always_comb begin
        nt_y_flip = 1'b0;
        if (cy == vsa_pkg::COARSE_Y_LAST) begin
            cy_next   = 5'd0;
            nt_y_flip = 1'b1;
        end else if (cy == vsa_pkg::COARSE_MAX) begin
            cy_next = 5'd0;
        end else begin
            cy_next = cy + 5'd1;
        end
        if (v[14:12] != vsa_pkg::FINE_Y_MAX) begin
            v_inc_y = {v[14:12] + 3'd1, v[11:0]};
        end else begin
            v_inc_y = {3'd0, v[11] ^ nt_y_flip, v[10], cy_next, v[4:0]};
        end
    end

    always_comb begin
        o_state = i_state;
        unique case (i_item.req_type)
            vsa_pkg::REQ_CTRL_WR: begin
                o_state.tmp_addr[11:10] = i_item.data_byte[1:0];
                o_state.step_by_row     = i_item.data_byte[2];
            end
            vsa_pkg::REQ_SCROLL_WR: begin
                if (!i_state.second_write) begin
                    o_state.fine_scroll_x = i_item.data_byte[2:0];
                    o_state.tmp_addr[4:0] = i_item.data_byte[7:3];
                    o_state.second_write  = 1'b1;
                end else begin
                    o_state.tmp_addr[14:12] = i_item.data_byte[2:0];
                    o_state.tmp_addr[9:5]   = i_item.data_byte[7:3];
                    o_state.second_write    = 1'b0;
                end
            end
            vsa_pkg::REQ_ADDR_WR: begin
                if (!i_state.second_write) begin
                    o_state.tmp_addr[14:8] = {1'b0, i_item.data_byte[5:0]};
                    o_state.second_write   = 1'b1;
                end else begin
                    o_state.tmp_addr[7:0] = i_item.data_byte;
                    o_state.cur_addr      = {i_state.tmp_addr[14:8], i_item.data_byte};
                    o_state.second_write  = 1'b0;
                end
            end
            vsa_pkg::REQ_DATA: begin
                o_state.cur_addr = v + (i_state.step_by_row ? vsa_pkg::ROW_STEP
                                                            : vsa_pkg::COL_STEP);
            end
            vsa_pkg::REQ_STATUS_RD: begin
                o_state.second_write = 1'b0;
            end
            vsa_pkg::REQ_INC_X: begin
                if (i_item.render_on) o_state.cur_addr = v_inc_x;
            end
            vsa_pkg::REQ_INC_Y: begin
                if (i_item.render_on) o_state.cur_addr = v_inc_y;
            end
            vsa_pkg::REQ_COPY_X: begin
                if (i_item.render_on) begin
                    o_state.cur_addr = (v & ~vsa_pkg::HORIZ_MASK)
                                     | (i_state.tmp_addr & vsa_pkg::HORIZ_MASK);
                end
            end
            vsa_pkg::REQ_COPY_Y: begin
                if (i_item.render_on) begin
                    o_state.cur_addr = (v & ~vsa_pkg::VERT_MASK)
                                     | (i_state.tmp_addr & vsa_pkg::VERT_MASK);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_result.current_addr    = o_state.cur_addr;
        o_result.access_addr     = (i_item.req_type == vsa_pkg::REQ_DATA) ? v
                                                                        : o_state.cur_addr;
        o_result.temp_addr       = o_state.tmp_addr;
        o_result.fine_x_out      = o_state.fine_scroll_x;
        o_result.toggle_out      = o_state.second_write;
        o_result.nametable_fetch = vsa_pkg::NT_BASE | {2'b00, o_state.cur_addr[11:0]};
        o_result.attribute_fetch = vsa_pkg::ATTR_BASE
                                 | {2'b00, o_state.cur_addr[11:10], 4'd0,
                                    o_state.cur_addr[9:7], o_state.cur_addr[4:2]};
    end

endmodule

`default_nettype wire

### sv/vram_scroll_address_unit.sv
// A request goes into the input register and its result into the result register;
// a result stall holds it in the input register. Throughput: one request per cycle unless
// the result side stalls; the v/t/fine X/toggle registers update as a request
// moves from the input register into the result register, so back-to-back requests chain.
// Reset (synchronous, active low): all scroll state zero, both pipeline registers empty.
// Top level of the VRAM scroll address unit; uses vsa_pkg and vsa_step.
`default_nettype none

module vram_scroll_address_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  vsa_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output vsa_pkg::t_out_item  o_out_item
);

    logic                   r_in_valid;
    vsa_pkg::t_in_item      r_in_item;
    logic                   r_out_valid;
    vsa_pkg::t_out_item     r_out_item;
    vsa_pkg::t_scroll_state r_state;
    vsa_pkg::t_scroll_state n_state;
    vsa_pkg::t_out_item     n_out_item;

    logic advance;
    logic in_xfer;

    vsa_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) r_in_item <= i_in_item;
        if (advance) r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

### sv/vsa_checker.sv
// Port-level checker for the VRAM scroll address unit, bound to the top level.
// Uses vsa_pkg.
`default_nettype none

module vsa_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                o_in_stall,
    input wire                o_out_valid,
    input wire                i_out_stall,
    input vsa_pkg::t_out_item o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a stalled result");

    a_empty_after_reset: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !o_out_valid)
        else $error("result valid straight after reset");

    a_nt_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.nametable_fetch
                         == (vsa_pkg::NT_BASE | {2'b00, o_out_item.current_addr[11:0]})))
        else $error("nametable fetch does not match current address");

    a_attr_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.attribute_fetch
                         == (vsa_pkg::ATTR_BASE
                             | {2'b00, o_out_item.current_addr[11:10], 4'd0,
                                o_out_item.current_addr[9:7],
                                o_out_item.current_addr[4:2]})))
        else $error("attribute fetch does not match current address");

endmodule

bind vram_scroll_address_unit vsa_checker u_vsa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);

`default_nettype wire

### tb/tb_vram_scroll_address_unit.sv
// Testbench for vram_scroll_address_unit: directed scroll/address cases, then random
// register-write pairs, data accesses and renderer runs under random idling on both sides.
// Depends on vsa_pkg and the RTL; results are checked by an in-bench scoreboard class.
`default_nettype none

module tb_vram_scroll_address_unit;

    timeunit 1ns;
    timeprecision 1ps;

    class scroll_scoreboard;
        logic [vsa_pkg::ADDR_W-1:0] v_addr;
        logic [vsa_pkg::ADDR_W-1:0] t_addr;
        logic [2:0]                 fine_x;
        logic                       toggle;
        logic                       row_step;
        vsa_pkg::t_out_item         expected_q[$];
        int unsigned                n_errors;

        function new();
            v_addr   = '0;
            t_addr   = '0;
            fine_x   = '0;
            toggle   = 1'b0;
            row_step = 1'b0;
            n_errors = 0;
        endfunction

        function void note_request(vsa_pkg::t_in_item req);
            vsa_pkg::t_out_item         res;
            logic [vsa_pkg::ADDR_W-1:0] v_prev;
            logic [7:0]                 d;
            v_prev = v_addr;
            d = req.data_byte;
            case (req.req_type)
                vsa_pkg::REQ_CTRL_WR: begin
                    t_addr[11:10] = d[1:0];
                    row_step = d[2];
                end
                vsa_pkg::REQ_SCROLL_WR: begin
                    if (!toggle) begin
                        fine_x = d[2:0];
                        t_addr[4:0] = d[7:3];
                    end else begin
                        t_addr[14:12] = d[2:0];
                        t_addr[9:5] = d[7:3];
                    end
                    toggle = ~toggle;
                end
                vsa_pkg::REQ_ADDR_WR: begin
                    if (!toggle) begin
                        t_addr[13:8] = d[5:0];
                        t_addr[14] = 1'b0;
                    end else begin
                        t_addr[7:0] = d;
                        v_addr = t_addr;
                    end
                    toggle = ~toggle;
                end
                vsa_pkg::REQ_DATA: begin
                    v_addr = v_addr + (row_step ? vsa_pkg::ROW_STEP : vsa_pkg::COL_STEP);
                end
                vsa_pkg::REQ_STATUS_RD: begin
                    toggle = 1'b0;
                end
                vsa_pkg::REQ_INC_X: begin
                    if (req.render_on) begin
                        if (v_addr[4:0] == vsa_pkg::COARSE_MAX) begin
                            v_addr[4:0] = '0;
                            v_addr[10] = ~v_addr[10];
                        end else begin
                            v_addr[4:0] = v_addr[4:0] + 5'd1;
                        end
                    end
                end
                vsa_pkg::REQ_INC_Y: begin
                    if (req.render_on) begin
                        if (v_addr[14:12] != vsa_pkg::FINE_Y_MAX) begin
                            v_addr[14:12] = v_addr[14:12] + 3'd1;
                        end else begin
                            v_addr[14:12] = '0;
                            if (v_addr[9:5] == vsa_pkg::COARSE_Y_LAST) begin
                                v_addr[9:5] = '0;
                                v_addr[11] = ~v_addr[11];
                            end else if (v_addr[9:5] == vsa_pkg::COARSE_MAX) begin
                                v_addr[9:5] = '0;
                            end else begin
                                v_addr[9:5] = v_addr[9:5] + 5'd1;
                            end
                        end
                    end
                end
                vsa_pkg::REQ_COPY_X: begin
                    if (req.render_on)
                        v_addr = (v_addr & ~vsa_pkg::HORIZ_MASK)
                               | (t_addr & vsa_pkg::HORIZ_MASK);
                end
                vsa_pkg::REQ_COPY_Y: begin
                    if (req.render_on)
                        v_addr = (v_addr & ~vsa_pkg::VERT_MASK)
                               | (t_addr & vsa_pkg::VERT_MASK);
                end
                default: ;
            endcase
            res.current_addr    = v_addr;
            res.access_addr     = (req.req_type == vsa_pkg::REQ_DATA) ? v_prev : v_addr;
            res.temp_addr       = t_addr;
            res.fine_x_out      = fine_x;
            res.toggle_out      = toggle;
            res.nametable_fetch = vsa_pkg::NT_BASE | {2'b00, v_addr[11:0]};
            res.attribute_fetch = vsa_pkg::ATTR_BASE | {2'b00, v_addr[11:10], 4'b0000,
                                  v_addr[9:7], v_addr[4:2]};
            expected_q.insert(expected_q.size(), res);
        endfunction

        function void check_field(string name, int unsigned exp_val, int unsigned act_val);
            if (exp_val !== act_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                n_errors++;
            end
        endfunction

        function void check_result(vsa_pkg::t_out_item got);
            vsa_pkg::t_out_item exp_res;
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: %0h", got);
                n_errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            check_field("current_addr", 32'(exp_res.current_addr), 32'(got.current_addr));
            check_field("access_addr", 32'(exp_res.access_addr), 32'(got.access_addr));
            check_field("temp_addr", 32'(exp_res.temp_addr), 32'(got.temp_addr));
            check_field("fine_x_out", 32'(exp_res.fine_x_out), 32'(got.fine_x_out));
            check_field("toggle_out", 32'(exp_res.toggle_out), 32'(got.toggle_out));
            check_field("nametable_fetch", 32'(exp_res.nametable_fetch),
                        32'(got.nametable_fetch));
            check_field("attribute_fetch", 32'(exp_res.attribute_fetch),
                        32'(got.attribute_fetch));
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               out_stall = 1'b0;
    vsa_pkg::t_in_item  in_item = '0;
    wire                in_stall;
    wire                out_valid;
    vsa_pkg::t_out_item out_item;

    logic        steady = 1'b0;
    int unsigned n_sent = 0;

    scroll_scoreboard sb = new();

    vram_scroll_address_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #(2_000_000);
        $display("[vram_scroll_address_unit] ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall)
                sb.note_request(in_item);
            if (out_valid && !out_stall)
                sb.check_result(out_item);
        end
    end

    // result side back-pressure, one random hold-off per transfer
    initial begin
        int unsigned hold;
        @(posedge rst_n);
        @(negedge clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, 9);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    function automatic vsa_pkg::t_in_item make_req(logic [3:0] kind, logic [7:0] d,
                                                   logic r);
        vsa_pkg::t_in_item req;
        req.req_type  = kind;
        req.data_byte = d;
        req.render_on = r;
        return req;
    endfunction

    task automatic send_request(vsa_pkg::t_in_item req);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_burst();
        int unsigned n;
        logic [3:0]  kind;
        steady = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 9))
            0, 1: begin
                if ($urandom_range(0, 1))
                    send_request(make_req(vsa_pkg::REQ_STATUS_RD, 8'($urandom),
                                          1'($urandom)));
                send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'($urandom), 1'($urandom)));
                send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'($urandom), 1'($urandom)));
            end
            2: begin
                send_request(make_req(vsa_pkg::REQ_ADDR_WR, 8'($urandom), 1'($urandom)));
                send_request(make_req(vsa_pkg::REQ_ADDR_WR, 8'($urandom), 1'($urandom)));
                n = $urandom_range(1, 6);
                repeat (n)
                    send_request(make_req(vsa_pkg::REQ_DATA, 8'($urandom), 1'($urandom)));
            end
            3: send_request(make_req(vsa_pkg::REQ_CTRL_WR, 8'($urandom), 1'($urandom)));
            4, 5, 6, 7: begin
                n = $urandom_range(4, 24);
                repeat (n) begin
                    case ($urandom_range(0, 7))
                        0, 1, 2: kind = vsa_pkg::REQ_INC_X;
                        3, 4:    kind = vsa_pkg::REQ_INC_Y;
                        5:       kind = vsa_pkg::REQ_COPY_X;
                        default: kind = vsa_pkg::REQ_COPY_Y;
                    endcase
                    send_request(make_req(kind, 8'($urandom), $urandom_range(0, 15) != 0));
                end
            end
            8: begin
                n = $urandom_range(1, 8);
                repeat (n)
                    send_request(make_req(vsa_pkg::REQ_DATA, 8'($urandom), 1'($urandom)));
            end
            default: begin
                n = $urandom_range(1, 4);
                repeat (n)
                    send_request(make_req(4'($urandom_range(0, 15)), 8'($urandom),
                                          1'($urandom)));
            end
        endcase
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // coarse Y 31, fine Y 7, fine X 7, both nametables; 32-step wrap at 15 bits
        send_request(make_req(vsa_pkg::REQ_STATUS_RD, 8'h00, 1'b0));
        send_request(make_req(vsa_pkg::REQ_CTRL_WR, 8'hFF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'hFF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'hFF, 1'b1));
        send_request(make_req(vsa_pkg::REQ_COPY_X, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_COPY_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_INC_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_COPY_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_DATA, 8'hFF, 1'b1));
        // single step wrap
        send_request(make_req(vsa_pkg::REQ_CTRL_WR, 8'h03, 1'b0));
        send_request(make_req(vsa_pkg::REQ_COPY_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_COPY_X, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_DATA, 8'h00, 1'b0));
        // coarse Y 29 then 30 at fine Y 7
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'h00, 1'b0));
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'hEF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_COPY_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_INC_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'h00, 1'b0));
        send_request(make_req(vsa_pkg::REQ_SCROLL_WR, 8'hF7, 1'b0));
        send_request(make_req(vsa_pkg::REQ_COPY_Y, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_INC_Y, 8'h00, 1'b1));
        // address pair clears t bit 14, then coarse X wrap
        send_request(make_req(vsa_pkg::REQ_ADDR_WR, 8'hFF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_ADDR_WR, 8'hFF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_INC_X, 8'h00, 1'b1));
        send_request(make_req(vsa_pkg::REQ_INC_X, 8'hFF, 1'b0));
        send_request(make_req(vsa_pkg::REQ_INC_Y, 8'hFF, 1'b0));
        send_request(make_req(4'd15, 8'hA5, 1'b1));
        drain_results();

        while (n_sent < 850) begin
            random_burst();
            if ($urandom_range(0, 49) == 0)
                drain_results();
        end
        steady = 1'b0;
        drain_results();
        repeat (8) @(posedge clk);

        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("[vram_scroll_address_unit] OK");
        else
            $display("[vram_scroll_address_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
